[src/bldm_pkg.sv]
`timescale 1ns / 1ps

package bldm_pkg;

   localparam int SAMPLE_COUNT = 6;
   localparam int TRIM_COUNT   = SAMPLE_COUNT - 2;

   localparam int LEVEL_W  = 7;
   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 12;
   localparam int MV_W     = 13;
   localparam int SUM_W    = MV_W + $clog2(SAMPLE_COUNT);
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [MV_W-1:0] mv_type;
   typedef code_type [SAMPLE_COUNT-1:0] code_array_type;

   localparam level_type LEVEL_FULL  = 7'd100;
   localparam level_type LEVEL_RESET = 7'd100;
   localparam level_type CURVE_TOP   = 7'd95;
   localparam level_type CURVE_HIGH  = 7'd80;
   localparam level_type CURVE_MID   = 7'd30;
   localparam level_type CURVE_LOW   = 7'd7;
   localparam level_type CHECK_LEVEL = 7'd2;
   localparam level_type HIGH_STEP   = 7'd5;
   localparam level_type MID_BASE    = 7'd50;
   localparam level_type LOW_BASE    = 7'd14;

   localparam mv_type CEILING_RESET   = 13'd4200;
   localparam mv_type THRESHOLD_RESET = 13'd3400;

   // reciprocals: x/7 = (x*293)>>11 for x < 683, x/22 = (x*745)>>14, x/6 = (x*43)>>8
   localparam int MID_MUL    = 5;
   localparam int MID_RECIP  = 293;
   localparam int LOW_MUL    = 35;
   localparam int LOW_RECIP  = 745;
   localparam int TINY_MUL   = 13;
   localparam int TINY_RECIP = 43;

   function automatic level_type display_curve(input level_type level);
      logic [8:0]  mid_x;
      logic [17:0] mid_p;
      logic [4:0]  low_d;
      logic [10:0] low_x;
      logic [20:0] low_p;
      logic [6:0]  tiny_x;
      logic [11:0] tiny_p;
      level_type   result;
      mid_x  = 9'(level - CURVE_MID) * 9'(MID_MUL);
      mid_p  = 18'(mid_x) * 18'(MID_RECIP);
      low_d  = level[4:0] - CURVE_LOW[4:0];
      low_x  = 11'(low_d) * 11'(LOW_MUL);
      low_p  = 21'(low_x) * 21'(LOW_RECIP);
      tiny_x = 7'(level[2:0]) * 7'(TINY_MUL);
      tiny_p = 12'(tiny_x) * 12'(TINY_RECIP);
      if (level >= CURVE_TOP) begin
         result = LEVEL_FULL;
      end else if (level >= CURVE_HIGH) begin
         result = level + HIGH_STEP;
      end else if (level >= CURVE_MID) begin
         result = MID_BASE + mid_p[17:11];
      end else if (level >= CURVE_LOW) begin
         result = LOW_BASE + low_p[20:14];
      end else begin
         result = 7'(tiny_p[11:8]);
      end
      return result;
   endfunction

endpackage

[src/bldm_sample_filter.sv]
`timescale 1ns / 1ps

module bldm_sample_filter (
   input  bldm_pkg::code_array_type codes,
   input  bldm_pkg::mv_type         ceiling,
   output bldm_pkg::mv_type         mean
);
   import bldm_pkg::*;

   mv_type               mv [SAMPLE_COUNT];
   mv_type               hi;
   mv_type               lo;
   logic [SUM_W-1:0]     sum;
   logic [SUM_W-1:0]     trimmed;
   logic [SUM_W-1:0]     quot;

   // code * 1.25 truncated = code + code/4, then clamp
   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         mv[i] = MV_W'(codes[i]) + MV_W'(codes[i] >> 2);
         if (mv[i] > ceiling) begin
            mv[i] = ceiling;
         end
      end
   end

   always_comb begin
      hi  = mv[0];
      lo  = mv[0];
      sum = SUM_W'(mv[0]);
      for (int i = 1; i < SAMPLE_COUNT; i++) begin
         if (mv[i] > hi) begin
            hi = mv[i];
         end
         if (mv[i] < lo) begin
            lo = mv[i];
         end
         sum = sum + SUM_W'(mv[i]);
      end
      trimmed = sum - SUM_W'(hi) - SUM_W'(lo);
      quot    = trimmed / SUM_W'(TRIM_COUNT);
   end

   assign mean = quot[MV_W-1:0];

endmodule

[src/battery_level_display_mapper_unit.sv]
`timescale 1ns / 1ps
// A request passes through the input register and then the result register before it is on the outputs.
// Throughput: one request per cycle unless rsp_stall holds a result; a waiting result does not block the next request.
// The result register is freed in the cycle it is taken, so stall passes back one stage.
// Reset (synchronous): pipeline empty, last valid level 100, registers at their reset values.

module battery_level_display_mapper_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bldm_pkg::ADDR_W-1:0]   paddr,
   input  logic [bldm_pkg::DATA_W-1:0]   pwdata,
   output logic [bldm_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bldm_pkg::BYTE_W-1:0]   req_level_byte,
   input  bldm_pkg::code_type            req_voltage_code_0,
   input  bldm_pkg::code_type            req_voltage_code_1,
   input  bldm_pkg::code_type            req_voltage_code_2,
   input  bldm_pkg::code_type            req_voltage_code_3,
   input  bldm_pkg::code_type            req_voltage_code_4,
   input  bldm_pkg::code_type            req_voltage_code_5,
   input  logic                          req_charge_full,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bldm_pkg::level_type           rsp_display_level,
   output bldm_pkg::level_type           rsp_held_level,
   output bldm_pkg::mv_type              rsp_filtered_voltage_mv,
   output logic                          rsp_voltage_checked
);
   import bldm_pkg::*;

   typedef enum logic [1:0] {
      REG_MODEL_19BIT = 2'd0,
      REG_CEILING     = 2'd1,
      REG_THRESHOLD   = 2'd2
   } reg_index_type;

   logic                   model_19bit_ff;
   mv_type                 ceiling_ff;
   mv_type                 threshold_ff;
   level_type              last_valid_ff;
   level_type              last_valid_in;

   logic                   s0_valid_ff;
   logic                   s0_valid_in;
   logic [BYTE_W-1:0]      s0_level_ff;
   code_array_type         s0_codes_ff;
   logic                   s0_full_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   level_type              disp_ff;
   level_type              disp_in;
   level_type              held_ff;
   level_type              held_in;
   mv_type                 filt_ff;
   mv_type                 filt_in;
   logic                   checked_ff;
   logic                   checked_in;

   logic                   s1_load;
   logic                   s0_move;
   logic                   req_take;
   logic                   csr_write;
   reg_index_type          csr_index;
   logic [BYTE_W-1:0]      raw;
   logic                   raw_ok;
   level_type              curve;
   mv_type                 mean;
   code_array_type         req_codes;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_MODEL_19BIT: prdata = DATA_W'(model_19bit_ff);
         REG_CEILING:     prdata = DATA_W'(ceiling_ff);
         REG_THRESHOLD:   prdata = DATA_W'(threshold_ff);
         default:         prdata = '0;
      endcase
   end

   assign req_codes = {req_voltage_code_5, req_voltage_code_4, req_voltage_code_3,
                       req_voltage_code_2, req_voltage_code_1, req_voltage_code_0};

   assign s1_load   = ~rsp_valid_ff | ~rsp_stall;
   assign s0_move   = s0_valid_ff & s1_load;
   assign req_stall = s0_valid_ff & ~s1_load;
   assign req_take  = req_valid & ~req_stall;

   assign s0_valid_in  = req_take | (s0_valid_ff & ~s1_load);
   assign rsp_valid_in = s1_load ? s0_valid_ff : rsp_valid_ff;

   assign raw    = model_19bit_ff ? {1'b0, s0_level_ff[BYTE_W-1:1]} : s0_level_ff;
   assign raw_ok = raw <= BYTE_W'(LEVEL_FULL);

   always_comb begin
      last_valid_in = last_valid_ff;
      if (s0_move && raw_ok) begin
         last_valid_in = raw[LEVEL_W-1:0];
      end
   end

   assign held_in = raw_ok ? raw[LEVEL_W-1:0] : last_valid_ff;
   assign curve   = display_curve(held_in);

   bldm_sample_filter u_filter (
      .codes   (s0_codes_ff),
      .ceiling (ceiling_ff),
      .mean    (mean)
   );

   always_comb begin
      disp_in    = curve;
      filt_in    = '0;
      checked_in = 1'b0;
      if (curve <= CHECK_LEVEL) begin
         filt_in    = mean;
         checked_in = 1'b1;
         disp_in    = LEVEL_W'(mean > threshold_ff);
      end
      if (s0_full_ff) begin
         disp_in = LEVEL_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_19bit_ff <= 1'b0;
         ceiling_ff     <= CEILING_RESET;
         threshold_ff   <= THRESHOLD_RESET;
         last_valid_ff  <= LEVEL_RESET;
         s0_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_MODEL_19BIT: model_19bit_ff <= pwdata[0];
               REG_CEILING:     ceiling_ff     <= pwdata[MV_W-1:0];
               REG_THRESHOLD:   threshold_ff   <= pwdata[MV_W-1:0];
               default:         ;
            endcase
         end
         last_valid_ff <= last_valid_in;
         s0_valid_ff   <= s0_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_level_ff <= req_level_byte;
         s0_codes_ff <= req_codes;
         s0_full_ff  <= req_charge_full;
      end
      if (s0_move) begin
         disp_ff    <= disp_in;
         held_ff    <= held_in;
         filt_ff    <= filt_in;
         checked_ff <= checked_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_display_level       = disp_ff;
   assign rsp_held_level          = held_ff;
   assign rsp_filtered_voltage_mv = filt_ff;
   assign rsp_voltage_checked     = checked_ff;

endmodule

[test/tb_battery_level_display_mapper_unit.sv]
`timescale 1ns / 1ps

module tb_battery_level_display_mapper_unit;
   import bldm_pkg::*;

   localparam int CSR_MODEL_19BIT  = 0;
   localparam int CSR_CEILING      = 1;
   localparam int CSR_THRESHOLD    = 2;
   localparam int MAX_GAP          = 19;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_COUNT      = 7;
   localparam int PHASE_REQUESTS   = 120;

   typedef struct packed {
      logic [BYTE_W-1:0] level_byte;
      code_array_type    codes;
      logic              charge_full;
   } gauge_sample_type;

   typedef struct packed {
      level_type display;
      level_type held;
      mv_type    filtered;
      logic      checked;
   } readout_type;

   typedef struct {
      gauge_sample_type sample;
      bit               fixed;
      readout_type      want;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_level_byte;
   code_type          req_voltage_code_0;
   code_type          req_voltage_code_1;
   code_type          req_voltage_code_2;
   code_type          req_voltage_code_3;
   code_type          req_voltage_code_4;
   code_type          req_voltage_code_5;
   logic              req_charge_full;
   logic              rsp_valid;
   logic              rsp_stall;
   level_type         rsp_display_level;
   level_type         rsp_held_level;
   mv_type            rsp_filtered_voltage_mv;
   logic              rsp_voltage_checked;

   bit                model_halved;
   int unsigned       ceiling_mv;
   int unsigned       threshold_mv;
   int unsigned       stored_level;

   readout_type       pending_readouts[$];
   directed_row_type  directed_rows[$];
   int                mismatches;
   bit                long_hold_pending;
   bit                req_burst;
   bit                rsp_burst;

   battery_level_display_mapper_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_level_byte          (req_level_byte),
      .req_voltage_code_0      (req_voltage_code_0),
      .req_voltage_code_1      (req_voltage_code_1),
      .req_voltage_code_2      (req_voltage_code_2),
      .req_voltage_code_3      (req_voltage_code_3),
      .req_voltage_code_4      (req_voltage_code_4),
      .req_voltage_code_5      (req_voltage_code_5),
      .req_charge_full         (req_charge_full),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_display_level       (rsp_display_level),
      .rsp_held_level          (rsp_held_level),
      .rsp_filtered_voltage_mv (rsp_filtered_voltage_mv),
      .rsp_voltage_checked     (rsp_voltage_checked)
   );

   always #10 clock = ~clock;

   function automatic readout_type predict_readout(gauge_sample_type s);
      readout_type r;
      int unsigned lvl;
      int unsigned disp;
      int unsigned mv;
      int unsigned sum;
      int unsigned hi;
      int unsigned lo;
      int unsigned filt;
      bit          checked;
      lvl = model_halved ? (s.level_byte >> 1) : s.level_byte;
      if (lvl > 100) begin
         lvl = stored_level;
      end else begin
         stored_level = lvl;
      end
      if (lvl >= 95) begin
         disp = 100;
      end else if (lvl >= 80) begin
         disp = lvl + 5;
      end else if (lvl >= 30) begin
         disp = 50 + ((lvl - 30) * 5) / 7;
      end else if (lvl >= 7) begin
         disp = 14 + ((lvl - 7) * 35) / 22;
      end else begin
         disp = (lvl * 13) / 6;
      end
      filt = 0;
      checked = 1'b0;
      if (disp <= 2) begin
         sum = 0;
         hi = 0;
         lo = 0;
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            mv = s.codes[i];
            mv = (mv * 1250) / 1000;
            if (mv > ceiling_mv) mv = ceiling_mv;
            if (i == 0 || mv > hi) hi = mv;
            if (i == 0 || mv < lo) lo = mv;
            sum += mv;
         end
         filt = (sum - hi - lo) / (SAMPLE_COUNT - 2);
         checked = 1'b1;
         disp = (filt > threshold_mv) ? 1 : 0;
      end
      if (s.charge_full) disp = 100;
      if (disp > 100) disp = 100;
      r.display = level_type'(disp);
      r.held = level_type'(lvl);
      r.filtered = mv_type'(filt);
      r.checked = checked;
      return r;
   endfunction

   function automatic gauge_sample_type random_sample();
      gauge_sample_type s;
      int               centre;
      int               code;
      int               kind;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s.level_byte = BYTE_W'($urandom_range(0, 3));
         4, 5: s.level_byte = BYTE_W'($urandom_range(0, 255));
         6: s.level_byte = BYTE_W'(model_halved ? $urandom_range(188, 222)
                                                : $urandom_range(94, 111));
         default: s.level_byte = BYTE_W'(model_halved ? $urandom_range(0, 201)
                                                      : $urandom_range(0, 100));
      endcase
      // codes around the threshold make the comparison tip both ways
      centre = (threshold_mv * 4) / 5;
      if (centre > 4095) centre = 4095;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         if (kind <= 4) begin
            code = $urandom_range(0, 4095);
         end else if (kind <= 7) begin
            code = centre + $urandom_range(0, 6) - 3;
         end else if (kind == 8) begin
            code = $urandom_range(0, 1) ? 4095 : 0;
         end else begin
            code = centre;
         end
         if (code < 0) code = 0;
         if (code > 4095) code = 4095;
         s.codes[i] = code_type'(code);
      end
      s.charge_full = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   function automatic void add_row(logic [BYTE_W-1:0] lb, code_array_type codes, logic cf,
                                   bit fixed, int disp, int held, int filt, bit checked);
      directed_row_type row;
      row.sample.level_byte = lb;
      row.sample.codes = codes;
      row.sample.charge_full = cf;
      row.fixed = fixed;
      row.want.display = level_type'(disp);
      row.want.held = level_type'(held);
      row.want.filtered = mv_type'(filt);
      row.want.checked = checked;
      directed_rows.push_back(row);
   endfunction

   task automatic write_csr(int index, logic [DATA_W-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = ADDR_W'(index * 4);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         CSR_MODEL_19BIT: model_halved = value[0];
         CSR_CEILING:     ceiling_mv = value[MV_W-1:0];
         CSR_THRESHOLD:   threshold_mv = value[MV_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic offer_request(gauge_sample_type s, bit fixed, readout_type want, int gap);
      readout_type got;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_level_byte = s.level_byte;
      req_voltage_code_0 = s.codes[0];
      req_voltage_code_1 = s.codes[1];
      req_voltage_code_2 = s.codes[2];
      req_voltage_code_3 = s.codes[3];
      req_voltage_code_4 = s.codes[4];
      req_voltage_code_5 = s.codes[5];
      req_charge_full = s.charge_full;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      got = predict_readout(s);
      pending_readouts.push_back(fixed ? want : got);
   endtask

   task automatic wait_for_readouts();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            long_hold_pending = 1'b0;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            n = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
               @(negedge clock);
               rsp_stall = 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall = 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : readout_check
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readouts.size() == 0) begin
            $display("%0t: unexpected readout display=%0d held=%0d filtered=%0d checked=%0d",
                     $time, rsp_display_level, rsp_held_level, rsp_filtered_voltage_mv,
                     rsp_voltage_checked);
            mismatches++;
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_display_level !== want.display) begin
               $display("%0t: display_level expected %0d got %0d",
                        $time, want.display, rsp_display_level);
               mismatches++;
            end
            if (rsp_held_level !== want.held) begin
               $display("%0t: held_level expected %0d got %0d",
                        $time, want.held, rsp_held_level);
               mismatches++;
            end
            if (rsp_filtered_voltage_mv !== want.filtered) begin
               $display("%0t: filtered_voltage_mv expected %0d got %0d",
                        $time, want.filtered, rsp_filtered_voltage_mv);
               mismatches++;
            end
            if (rsp_voltage_checked !== want.checked) begin
               $display("%0t: voltage_checked expected %0d got %0d",
                        $time, want.checked, rsp_voltage_checked);
               mismatches++;
            end
         end
      end
   end

   initial begin : limit
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      readout_type      none;
      gauge_sample_type s;
      int               flood;
      int               gap;
      int unsigned      m;
      int unsigned      c;
      int unsigned      t;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_level_byte = '0;
      req_voltage_code_0 = '0;
      req_voltage_code_1 = '0;
      req_voltage_code_2 = '0;
      req_voltage_code_3 = '0;
      req_voltage_code_4 = '0;
      req_voltage_code_5 = '0;
      req_charge_full = 1'b0;
      mismatches = 0;
      long_hold_pending = 1'b0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      none = '0;
      model_halved = 1'b0;
      ceiling_mv = CEILING_RESET;
      threshold_mv = THRESHOLD_RESET;
      stored_level = LEVEL_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: ceiling 4200, threshold 3400, last valid level 100
      add_row(8'd255, {6{12'd0}}, 1'b0, 1, 100, 100, 0, 0);
      add_row(8'd100, {6{12'd0}}, 1'b0, 1, 100, 100, 0, 0);
      add_row(8'd0, {6{12'd4095}}, 1'b0, 1, 1, 0, 4200, 1);
      add_row(8'd0, {6{12'd0}}, 1'b0, 1, 0, 0, 0, 1);
      add_row(8'd101, {6{12'd0}}, 1'b0, 1, 0, 0, 0, 1);
      add_row(8'd0, {6{12'd0}}, 1'b1, 1, 100, 0, 0, 1);
      add_row(8'd0, {6{12'd2720}}, 1'b0, 1, 0, 0, 3400, 1);
      add_row(8'd0, {6{12'd2721}}, 1'b0, 1, 1, 0, 3401, 1);
      add_row(8'd0, {12'd100, 12'd3000, 12'd2000, 12'd1000, 12'd4095, 12'd0},
              1'b0, 0, 0, 0, 0, 0);
      add_row(8'd0, {12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd1, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd2, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd6, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd7, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd29, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd30, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd79, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd80, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd94, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd95, {6{12'd3000}}, 1'b0, 0, 0, 0, 0, 0);
      add_row(8'd128, {6{12'd0}}, 1'b0, 1, 100, 95, 0, 0);
      add_row(8'd50, {6{12'd0}}, 1'b1, 0, 0, 0, 0, 0);
      add_row(8'd200, {6{12'd0}}, 1'b1, 0, 0, 0, 0, 0);
      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].sample, directed_rows[i].fixed, directed_rows[i].want,
                       $urandom_range(0, 3));
      end
      wait_for_readouts();

      for (int p = 1; p <= PHASE_COUNT; p++) begin
         case (p)
            1: begin m = 1; c = 4350; t = 0; end
            2: begin m = 0; c = 4200; t = 4350; end
            3: begin m = 1; c = 4200; t = 3400; end
            4: begin m = 0; c = 4350; t = 4200; end
            5: begin m = 0; c = 8191; t = 8191; end
            6: begin m = 1; c = 1000; t = 999; end
            default: begin
               m = $urandom_range(0, 1);
               c = $urandom_range(4200, 4350);
               t = $urandom_range(0, 4350);
            end
         endcase
         write_csr(CSR_MODEL_19BIT, m);
         write_csr(CSR_CEILING, c);
         write_csr(CSR_THRESHOLD, t);
         flood = 0;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 40 == 0) begin
               req_burst = ($urandom_range(0, 3) == 0);
               rsp_burst = ($urandom_range(0, 3) == 0);
            end
            // output held off while requests keep coming, so the pipe backs up
            if (p == 1 && n == 30) begin
               long_hold_pending = 1'b1;
               flood = 20;
            end
            gap = (req_burst || flood > 0) ? 0 : $urandom_range(0, MAX_GAP);
            if (flood > 0) flood--;
            s = random_sample();
            offer_request(s, 1'b0, none, gap);
            if (p == 3 && n == 60) wait_for_readouts();
         end
         wait_for_readouts();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
